@@ rtl/wrlg_pkg.sv @@
// Package for the windowed RMS level gate: field widths, register indexes,
// payload structs and the command and status groups shared by its modules.
// Depends on nothing; every other file of the block uses it.
package wrlg_pkg;

    // Default largest half window; the history holds twice this many samples.
    localparam int HALF_WINDOW_MAX_DEF = 64;

    // Most decisions given out for one accepted sample.
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 32;
    localparam int HW_CFG_W   = 7;
    localparam int THR_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_THRESHOLD = 2'd2;

    // Register values after reset.
    localparam logic                FMT_RESET = 1'b0;
    localparam logic [HW_CFG_W-1:0] HW_RESET  = 7'd64;
    localparam logic [THR_W-1:0]    THR_RESET = 31'd10737418;

    // One input item.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } wrlg_in_t;

    // One result item.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             above;
        logic             last_result;
    } wrlg_out_t;

    // Configuration register contents.
    typedef struct packed {
        logic                sample_format;
        logic [HW_CFG_W-1:0] half_window;
        logic [THR_W-1:0]    power_threshold;
    } wrlg_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic setup;
        logic mult;
        logic emit;
        logic emit_last;
        logic clr_stream;
    } wrlg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pend_zero;
        logic pend_one;
        logic pend_below_h;
        logic sum_busy;
        logic out_free;
    } wrlg_stat_t;

endpackage

@@ rtl/windowed_rms_level_gate_unit.sv @@
// Top level of the windowed RMS level gate: configuration registers and the
// controller and datapath instances.
// Depends on wrlg_pkg, wrlg_ctrl and wrlg_dp.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid / in_stall   in_data  (sample, last_sample)
//   out       output     out_valid / out_stall out_data (position, above, last_result)
//   cfg       input      cfg_wr_en             cfg_index, cfg_data
//
// Each decision goes through a check, one history memory read per window sample (the
// window holds back + fwd samples, up to twice the half window), the drain of the read,
// square and accumulate stages, then a multiply and a hand-off, which waits while the
// output is not free. A sample adds an intake and a closing check; in steady streaming
// it causes one decision, and the final sample of a stream causes up to one decision
// per pending position.
// Reset is asynchronous and active low; the history memory has no reset.
// A stalled result waits in the output register while the next decision is
// worked out; input is stalled until all decisions of the current sample are made.
module windowed_rms_level_gate_unit #(
    parameter int HALF_WINDOW_MAX = wrlg_pkg::HALF_WINDOW_MAX_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  wrlg_pkg::wrlg_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output wrlg_pkg::wrlg_out_t                  out_data,
    input  logic                                 cfg_wr_en,
    input  logic [wrlg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wrlg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    wrlg_pkg::wrlg_cfg_t  cfg_reg;
    wrlg_pkg::wrlg_cmd_t  cmd;
    wrlg_pkg::wrlg_stat_t stat;

    // Configuration registers; writes to unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_format   <= wrlg_pkg::FMT_RESET;
            cfg_reg.half_window     <= wrlg_pkg::HW_RESET;
            cfg_reg.power_threshold <= wrlg_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wrlg_pkg::CFG_SAMPLE_FORMAT:
                    cfg_reg.sample_format <= cfg_data[0];
                wrlg_pkg::CFG_HALF_WINDOW:
                    cfg_reg.half_window <= cfg_data[wrlg_pkg::HW_CFG_W-1:0];
                wrlg_pkg::CFG_POWER_THRESHOLD:
                    cfg_reg.power_threshold <= cfg_data[wrlg_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Controller.
    wrlg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .last_sample (in_data.last_sample),
        .stat        (stat),
        .cmd         (cmd),
        .in_stall    (in_stall)
    );

    // Datapath.
    wrlg_dp #(
        .HALF_WINDOW_MAX (HALF_WINDOW_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .sample    (in_data.sample),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ rtl/wrlg_ctrl.sv @@
// Controller of the windowed RMS level gate: sequences sample intake,
// window summation, threshold test and result hand-off.
// Depends on wrlg_pkg for the command and status structs.
module wrlg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_sample,
    input  wrlg_pkg::wrlg_stat_t stat,
    output wrlg_pkg::wrlg_cmd_t  cmd,
    output logic                 in_stall
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_RUN   = 5'b00100,
        S_MULT  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                            state_reg, state_next;
    logic                              last_reg, last_next;
    logic [wrlg_pkg::RES_CNT_W-1:0]    k_reg, k_next;
    logic                              done;

    // No further decision for this sample: nothing pending, burst limit hit,
    // or the next window is not yet complete outside a flush.
    assign done = stat.pend_zero
                  || (k_reg == wrlg_pkg::RES_CNT_W'(wrlg_pkg::MAX_RESULTS))
                  || (!last_reg && stat.pend_below_h);

    // Input is taken only while waiting for a sample.
    assign in_stall = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        k_next     = k_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    last_next  = last_sample;
                    k_next     = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (done)
                begin
                    cmd.clr_stream = last_reg;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.setup  = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (!stat.sum_busy)
                begin
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    // The final decision of a flush: last pending one, or the
                    // last one the burst limit lets through.
                    cmd.emit_last = last_reg && (stat.pend_one
                        || (k_reg == wrlg_pkg::RES_CNT_W'(wrlg_pkg::MAX_RESULTS - 1)));
                    k_next        = k_reg + 1'b1;
                    state_next    = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            k_reg     <= k_next;
        end
    end

endmodule

@@ rtl/wrlg_dp.sv @@
// Datapath of the windowed RMS level gate: sample history memory, stream
// counters, sum-of-squares accumulator, threshold product and result register.
// Depends on wrlg_pkg for field widths and the command and status structs.
module wrlg_dp #(
    parameter int HALF_WINDOW_MAX = wrlg_pkg::HALF_WINDOW_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wrlg_pkg::wrlg_cfg_t                 cfg,
    input  logic signed [wrlg_pkg::SAMPLE_W-1:0] sample,
    input  wrlg_pkg::wrlg_cmd_t                 cmd,
    output wrlg_pkg::wrlg_stat_t                stat,
    input  logic                                out_stall,
    output logic                                out_valid,
    output wrlg_pkg::wrlg_out_t                 out_data
);

    localparam int SAMPLE_W = wrlg_pkg::SAMPLE_W;
    localparam int POS_W    = wrlg_pkg::POS_W;
    localparam int THR_W    = wrlg_pkg::THR_W;
    localparam int DEPTH    = 2 * HALF_WINDOW_MAX;
    localparam int AW       = $clog2(DEPTH);
    localparam int HW_W     = $clog2(HALF_WINDOW_MAX + 1);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int SUM_W    = 2 * SAMPLE_W - 2 + CNT_W;
    localparam int CMP_W    = CNT_W + THR_W;
    localparam logic [wrlg_pkg::HW_CFG_W-1:0] HW_CAP = wrlg_pkg::HW_CFG_W'(HALF_WINDOW_MAX);

    // Sample history; entries are read only after they have been written.
    logic signed [SAMPLE_W-1:0] hist_mem [DEPTH];

    logic [AW-1:0]              wslot_reg;
    logic [POS_W-1:0]           seen_reg;
    logic [POS_W-1:0]           next_reg;
    logic [AW-1:0]              rd_addr_reg;
    logic [CNT_W-1:0]           iss_left_reg;
    logic                       rd_v_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       sq_v_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [SUM_W-1:0]           acc_reg;
    logic [CNT_W-1:0]           n_reg;
    logic [CMP_W-1:0]           prod_reg;
    logic                       out_valid_reg;
    wrlg_pkg::wrlg_out_t        out_reg;

    logic [HW_W-1:0]            h_eff;
    logic [POS_W-1:0]           h_ext;
    logic [POS_W-1:0]           pend;
    logic                       pend_lt_h;
    logic [HW_W-1:0]            back;
    logic [HW_W-1:0]            fwd;
    logic [CNT_W-1:0]           win_n;
    logic [CNT_W-1:0]           span;
    logic [CNT_W-1:0]           wslot_ext;
    logic [CNT_W-1:0]           start_ext;
    logic signed [SAMPLE_W-1:0] conv;
    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [CMP_W-1:0]           prod_full;
    logic                       above;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(DEPTH - 1))
            r = '0;
        else
            r = a + 1'b1;
        return r;
    endfunction

    // Effective half window: zero counts as one, large values are capped.
    always_comb
    begin
        if (cfg.half_window == '0)
            h_eff = HW_W'(1);
        else if (cfg.half_window > HW_CAP)
            h_eff = HW_W'(HALF_WINDOW_MAX);
        else
            h_eff = cfg.half_window[HW_W-1:0];
    end

    // Positions pending a decision; never more than the largest half window.
    assign h_ext     = POS_W'(h_eff);
    assign pend      = seen_reg - next_reg;
    assign pend_lt_h = (pend < h_ext);

    // Window extent around the next position, cut at the stream edges.
    assign back  = (next_reg < h_ext) ? next_reg[HW_W-1:0] : h_eff;
    assign fwd   = pend_lt_h ? pend[HW_W-1:0] : h_eff;
    assign win_n = CNT_W'(back) + CNT_W'(fwd);

    // Oldest history slot of the window, wrapped round the history depth.
    assign span      = CNT_W'(pend[HW_W-1:0]) + CNT_W'(back);
    assign wslot_ext = CNT_W'(wslot_reg);
    assign start_ext = (wslot_ext >= span) ? (wslot_ext - span)
                                           : (wslot_ext + CNT_W'(DEPTH) - span);

    // Offset 8-bit samples become signed by inverting their top bit.
    assign conv = cfg.sample_format
                  ? {{(SAMPLE_W - 8){~sample[7]}}, ~sample[7], sample[6:0]}
                  : sample;

    // Square of the sample just read, and the count times threshold product.
    assign sq_full   = rd_data_reg * rd_data_reg;
    assign prod_full = {{THR_W{1'b0}}, n_reg} * {{CNT_W{1'b0}}, cfg.power_threshold};

    // Threshold test; an empty window is never above.
    assign above = (n_reg != '0) && (CMP_W'(acc_reg) > prod_reg);

    // Status towards the controller.
    assign stat.pend_zero    = (pend == '0);
    assign stat.pend_one     = (pend == POS_W'(1));
    assign stat.pend_below_h = pend_lt_h;
    assign stat.sum_busy     = (iss_left_reg != '0) || rd_v_reg || sq_v_reg;
    assign stat.out_free     = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // History memory write and registered read, square and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            hist_mem[wslot_reg] <= conv;
        if (iss_left_reg != '0)
            rd_data_reg <= hist_mem[rd_addr_reg];
        sq_reg <= sq_full[SQ_W-1:0];
        if (cmd.emit)
        begin
            out_reg.position    <= next_reg;
            out_reg.above       <= above;
            out_reg.last_result <= cmd.emit_last;
        end
    end

    // Stream counters, read sequencer, accumulator and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wslot_reg     <= '0;
            seen_reg      <= '0;
            next_reg      <= '0;
            rd_addr_reg   <= '0;
            iss_left_reg  <= '0;
            rd_v_reg      <= 1'b0;
            sq_v_reg      <= 1'b0;
            acc_reg       <= '0;
            n_reg         <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                wslot_reg <= slot_inc(wslot_reg);
                seen_reg  <= seen_reg + 1'b1;
            end

            if (cmd.clr_stream)
            begin
                seen_reg <= '0;
                next_reg <= '0;
            end
            else if (cmd.emit)
            begin
                next_reg <= next_reg + 1'b1;
            end

            // Read one history entry per cycle across the window.
            if (cmd.setup)
            begin
                rd_addr_reg  <= start_ext[AW-1:0];
                iss_left_reg <= win_n;
                n_reg        <= win_n;
            end
            else if (iss_left_reg != '0)
            begin
                rd_addr_reg  <= slot_inc(rd_addr_reg);
                iss_left_reg <= iss_left_reg - 1'b1;
            end
            rd_v_reg <= (iss_left_reg != '0);
            sq_v_reg <= rd_v_reg;

            // Sum of squares over the window.
            if (cmd.setup)
                acc_reg <= '0;
            else if (sq_v_reg)
                acc_reg <= acc_reg + SUM_W'(sq_reg);

            if (cmd.mult)
                prod_reg <= prod_full;

            // Result register: filled on a decision, emptied by a transfer.
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ verif/tb_windowed_rms_level_gate_unit.sv @@
// Self-checking testbench for the windowed RMS level gate. It drives sample streams
// with random gaps and output stalls, predicts every level decision and checks each one.
// Depends on wrlg_pkg and windowed_rms_level_gate_unit.
module tb_windowed_rms_level_gate_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import wrlg_pkg::*;

    localparam int HMAX          = HALF_WINDOW_MAX_DEF;
    localparam int HIST_LEN      = 2 * HMAX;
    localparam int RANDOM_ITEMS  = 354;
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int MAX_PRINTS    = 200;

    localparam logic [THR_W-1:0] THR_TOP        = '1;
    localparam logic [THR_W-1:0] THR_FULL_SCALE = 31'h4000_0000;

    // Block ports.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    wrlg_in_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    wrlg_out_t             out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the configuration and of the stream state.
    logic                  fmt_q        = FMT_RESET;
    logic [HW_CFG_W-1:0]   half_q       = HW_RESET;
    logic [THR_W-1:0]      thr_q        = THR_RESET;
    int                    history [HIST_LEN];
    int                    hist_wr      = 0;
    logic [POS_W-1:0]      stream_count = '0;
    logic [POS_W-1:0]      decide_pos   = '0;

    wrlg_in_t              pending_samples [$];
    wrlg_out_t             level_decisions [$];

    // Handshake and pacing state.
    logic                  in_taken       = 1'b0;
    bit                    quiet          = 1'b0;
    bit                    hold_req       = 1'b0;
    int                    hold_count     = 0;
    int                    tx_gap         = 0;
    int                    rx_gap         = 0;
    int                    cycle_count    = 0;
    int                    mismatch_count = 0;
    int                    items_queued   = 0;

    windowed_rms_level_gate_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Half window as the block uses it: zero counts as one, large values are capped.
    function automatic int effective_half();
        if (half_q == 0)
            return 1;
        if (half_q > HMAX)
            return HMAX;
        return int'(half_q);
    endfunction

    // Level test for one position; ahead is the number of samples at or after it.
    function automatic logic window_is_loud(input logic [POS_W-1:0] pos,
                                            input logic [POS_W-1:0] ahead, input int h);
        int                back;
        int                fwd;
        int                idx;
        int                d;
        longint            age;
        longint            v;
        longint unsigned   energy;
        longint unsigned   count;
        back   = (pos < h) ? int'(pos) : h;
        fwd    = (ahead < h) ? int'(ahead) : h;
        energy = 0;
        count  = 0;
        for (d = -back; d < fwd; d++)
        begin
            age = longint'(ahead) - 1 - d;
            // Samples beyond the reach of the history are left out.
            if (age >= 0 && age < HIST_LEN)
            begin
                idx    = (hist_wr + HIST_LEN - 1 - int'(age)) % HIST_LEN;
                v      = history[idx];
                energy += v * v;
                count++;
            end
        end
        if (count == 0)
            return 1'b0;
        return energy > count * thr_q;
    endfunction

    // Take one sample into the shadow state and queue the decisions it releases.
    function automatic void advance_level_gate(input wrlg_in_t item);
        int               h;
        int               v;
        int               made;
        logic [POS_W-1:0] ahead;
        wrlg_out_t        res;
        h = effective_half();
        if (fmt_q)
            v = int'(item.sample[7:0]) - 128;
        else
            v = int'($signed(item.sample));
        history[hist_wr] = v;
        hist_wr          = (hist_wr + 1) % HIST_LEN;
        stream_count     += 1;
        made             = 0;
        ahead            = stream_count - decide_pos;
        while (made < MAX_RESULTS && ahead != 0 && (item.last_sample || ahead >= h))
        begin
            res.position    = decide_pos;
            res.above       = window_is_loud(decide_pos, ahead, h);
            res.last_result = 1'b0;
            level_decisions = {level_decisions, res};
            decide_pos += 1;
            made++;
            ahead = stream_count - decide_pos;
        end
        // The final sample marks the last decision given and restarts the stream.
        if (item.last_sample)
        begin
            if (made > 0)
            begin
                res             = level_decisions.pop_back();
                res.last_result = 1'b1;
                level_decisions = {level_decisions, res};
            end
            stream_count = '0;
            decide_pos   = '0;
        end
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SAMPLE_FORMAT:   fmt_q  = value[0];
            CFG_HALF_WINDOW:     half_q = value[HW_CFG_W-1:0];
            CFG_POWER_THRESHOLD: thr_q  = value[THR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Wait until every sample has been taken and every decision has come back.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || level_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_sample(input logic [15:0] s, input logic last);
        wrlg_in_t item;
        item.sample      = s;
        item.last_sample = last;
        pending_samples  = {pending_samples, item};
        items_queued++;
    endfunction

    // Random sample of roughly the given amplitude, with silence and full-range words.
    function automatic logic [15:0] pick_sample(input bit fmt8, input int amp);
        int          v;
        logic [15:0] word;
        word = 16'($urandom);
        v    = int'($urandom_range(0, 2 * amp)) - amp;
        if ($urandom_range(0, 7) == 0)
            v = 0;
        if (fmt8)
        begin
            v = v + 128;
            if (v > 255)
                v = 255;
            word[7:0] = 8'(v);
        end
        else if ($urandom_range(0, 7) != 0)
        begin
            if (v > 32767)
                v = 32767;
            word = 16'(v);
        end
        return word;
    endfunction

    function automatic void queue_stream(input int len, input bit fmt8, input int amp,
                                         input bit close);
        int n;
        for (n = 0; n < len; n++)
            queue_sample(pick_sample(fmt8, amp), close && (n == len - 1));
    endfunction

    // Check each result transfer, then take each sample transfer into the prediction.
    always @(posedge clk)
    begin
        wrlg_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (level_decisions.size() == 0)
                    flag_mismatch($sformatf("unexpected decision for position %0d",
                                            out_data.position));
                else
                begin
                    want = level_decisions.pop_front();
                    if (out_data.position !== want.position)
                        flag_mismatch($sformatf("position %0d, wanted %0d",
                                                out_data.position, want.position));
                    if (out_data.above !== want.above)
                        flag_mismatch($sformatf("above %b at position %0d, wanted %b",
                                                out_data.above, want.position, want.above));
                    if (out_data.last_result !== want.last_result)
                        flag_mismatch($sformatf("last_result %b at position %0d, wanted %b",
                                                out_data.last_result, want.position,
                                                want.last_result));
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
                advance_level_gate(pending_samples.pop_front());
        end
    end

    // Sample sender: holds an offer until its transfer, with random bursts of idling.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
        begin
            // The current offer is still stalled, so it stays as it is.
        end
        else if (tx_gap != 0)
        begin
            in_valid <= 1'b0;
            tx_gap   <= tx_gap - 1;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            tx_gap   <= $urandom_range(0, 9);
        end
        else if (pending_samples.size() != 0)
        begin
            in_valid <= 1'b1;
            in_data  <= pending_samples[0];
        end
        else
            in_valid <= 1'b0;
    end

    // Result receiver: one long hold-off on request, otherwise random stall bursts.
    always @(negedge clk)
    begin
        if (hold_req && hold_count < LONG_HOLD)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else if (rx_gap != 0)
        begin
            out_stall <= 1'b1;
            rx_gap    <= rx_gap - 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_stall <= 1'b1;
            rx_gap    <= $urandom_range(0, 9);
        end
        else
            out_stall <= 1'b0;
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: directed streams first, then random phases with settings changes between.
    initial
    begin
        int          heff;
        int          amp;
        int          len;
        int          left;
        int          streams;
        int          s;
        int          hsel;
        int          random_start;
        bit          fmt8;
        bit          close;
        longint      lvl;
        logic [31:0] raw;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A short stream under the reset settings, flushed by its final sample.
        queue_sample(16'h1234, 1'b0);
        queue_sample(16'hC000, 1'b0);
        queue_sample(16'h0400, 1'b1);
        wait_idle();

        // Zero threshold: silence is never above, anything else is.
        write_reg(CFG_SAMPLE_FORMAT, 31'd0);
        write_reg(CFG_HALF_WINDOW, 31'd2);
        write_reg(CFG_POWER_THRESHOLD, 31'd0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'hFFFF, 1'b1);
        wait_idle();

        // Full-scale threshold: even the largest samples only reach it.
        write_reg(CFG_HALF_WINDOW, 31'd1);
        write_reg(CFG_POWER_THRESHOLD, THR_FULL_SCALE);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h7FFF, 1'b1);
        wait_idle();

        // Offset 8-bit samples, then format and window changes inside one stream.
        write_reg(CFG_SAMPLE_FORMAT, 31'd1);
        write_reg(CFG_HALF_WINDOW, 31'd3);
        write_reg(CFG_POWER_THRESHOLD, 31'd100);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h5580, 1'b0);
        queue_sample(16'hAA7F, 1'b0);
        queue_sample(16'h12C0, 1'b0);
        wait_idle();
        write_reg(CFG_SAMPLE_FORMAT, 31'd0);
        queue_sample(16'h012C, 1'b0);
        queue_sample(16'hFFCE, 1'b0);
        wait_idle();
        // A shrinking window releases the pending positions in one burst.
        write_reg(CFG_HALF_WINDOW, 31'd1);
        queue_sample(16'h000A, 1'b0);
        wait_idle();
        // A growing window holds decisions back until enough samples arrive.
        write_reg(CFG_HALF_WINDOW, 31'd6);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h0005, 1'b1);
        wait_idle();

        // Out-of-range half windows: zero acts as one, large values as the maximum.
        write_reg(CFG_HALF_WINDOW, 31'd0);
        write_reg(CFG_POWER_THRESHOLD, THR_RESET);
        queue_sample(16'h0007, 1'b0);
        queue_sample(16'h0000, 1'b1);
        wait_idle();
        write_reg(CFG_HALF_WINDOW, 31'd127);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h0064, 1'b1);
        wait_idle();

        random_start = items_queued;
        while (items_queued - random_start < RANDOM_ITEMS)
        begin
            // Once, the receiver holds off while samples keep coming, so the block backs up.
            if (!hold_req && items_queued - random_start >= RANDOM_ITEMS / 2)
            begin
                hold_req = 1'b1;
                write_reg(CFG_SAMPLE_FORMAT, 31'd0);
                write_reg(CFG_HALF_WINDOW, 31'd2);
                queue_stream(40, 1'b0, 20000, 1'b1);
                wait_idle();
            end
            quiet = (items_queued - random_start >= RANDOM_ITEMS - 60);

            fmt8   = ($urandom_range(0, 3) == 0);
            raw    = $urandom;
            raw[0] = fmt8;
            write_reg(CFG_SAMPLE_FORMAT, raw[CFG_DATA_W-1:0]);

            case ($urandom_range(0, 15))
                0:       hsel = 0;
                1:       hsel = HMAX;
                2:       hsel = $urandom_range(HMAX + 1, 127);
                3, 4:    hsel = $urandom_range(9, 40);
                default: hsel = $urandom_range(1, 8);
            endcase
            raw      = $urandom;
            raw[6:0] = 7'(hsel);
            write_reg(CFG_HALF_WINDOW, raw[CFG_DATA_W-1:0]);

            if (fmt8)
                amp = $urandom_range(1, 128);
            else
                amp = $urandom_range(1, 1 << $urandom_range(1, 15));
            // Threshold mostly near the mean square of the chosen amplitude.
            case ($urandom_range(0, 15))
                0:       lvl = 0;
                1:       lvl = THR_TOP;
                2:       lvl = THR_FULL_SCALE;
                default: lvl = longint'(amp) * amp * $urandom_range(8, 48) / 96;
            endcase
            write_reg(CFG_POWER_THRESHOLD, lvl[CFG_DATA_W-1:0]);

            heff    = effective_half();
            streams = $urandom_range(1, 3);
            for (s = 0; s < streams; s++)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(130, 180);
                else
                    len = $urandom_range(1, (heff > 12) ? 30 : 3 * heff + 4);
                // Keep the total number of samples close to the planned count.
                left = RANDOM_ITEMS - (items_queued - random_start);
                if (len > left)
                    len = (left > 0) ? left : 1;
                // The final stream of a phase is sometimes left open across the next change.
                close = (s < streams - 1) || quiet || ($urandom_range(0, 3) != 0);
                queue_stream(len, fmt8, amp, close);
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/wrlg_pkg.sv
rtl/wrlg_ctrl.sv
rtl/wrlg_dp.sv
rtl/windowed_rms_level_gate_unit.sv
verif/tb_windowed_rms_level_gate_unit.sv
